@@ sv/itcf_pkg.sv @@
`timescale 1ns / 1ps

package itcf_pkg;

   localparam int CORDIC_STEPS    = 16;
   localparam int ACCUM_FRAC_BITS = 16;

   localparam int TAB_LEN     = 24;
   localparam int CORD_ITERS  = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
   localparam int STEP_W      = $clog2(TAB_LEN);
   localparam int CW          = 27;
   localparam int ZW          = 26;
   localparam int SQ_W        = 48;
   localparam int SQRT_ITERS  = SQ_W / 2;
   localparam int MAG_W       = 19;
   localparam int DT_W        = 32;
   localparam int P_W         = MAG_W + DT_W;
   localparam int CUT_SH      = 5;
   localparam int NUM_W       = P_W + ACCUM_FRAC_BITS - CUT_SH + 1;
   localparam int DIG_W       = 11;
   localparam int N_DIG       = (NUM_W + DIG_W - 1) / DIG_W;
   localparam int NUMP_W      = N_DIG * DIG_W;
   localparam int DIV_ITERS   = 2 * N_DIG;
   localparam int REM_W       = 21;
   localparam int Y_W         = REM_W + DIG_W;
   localparam int RCP_W       = 33;
   localparam int RCP_SH      = Y_W + REM_W;
   localparam int QW          = ACCUM_FRAC_BITS + 27;
   localparam int ACC_W       = 48;
   localparam int SUM_W       = 66;
   localparam int CNT_W       = $clog2(SQRT_ITERS + 1);
   localparam int REQ_W       = 176;
   localparam int RSP_W       = 168;

   // rate scale 250 and five fraction bits fold out of the divisor
   localparam longint RATE_DEN = 64'd16383000000;
   localparam longint DEN_CUT  = 64'd250 << CUT_SH;
   localparam longint DIV_DEN  = RATE_DEN / DEN_CUT;
   localparam logic [REM_W-1:0] DIV_B    = REM_W'(DIV_DEN);
   localparam logic [REM_W-1:0] DIV_HALF = REM_W'(RATE_DEN / 2 / DEN_CUT);
   localparam logic [RCP_W-1:0] DIV_RCP  = RCP_W'(((64'd1 << RCP_SH) / DIV_DEN) + 1);

   localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;

   localparam logic [16:0] ALPHA_RESET = 17'd62259;
   localparam logic [16:0] ALPHA_ONE   = 17'd65536;

   localparam logic [1:0] CSR_GYRO_RANGE   = 2'd0;
   localparam logic [1:0] CSR_GYRO_BIAS    = 2'd1;
   localparam logic [1:0] CSR_FILTER_ALPHA = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE, S_SQ_A, S_SQ_B, S_SQRT_INIT, S_SQRT, S_MUL, S_NUM, S_DIV,
      S_ACC, S_CORD_LOAD, S_CORD, S_CORD_STORE, S_MAC_ANG, S_MAC_LO, S_MAC_HI, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      ANG_ROLL, ANG_PITCH, ANG_YAW
   } angle_type;

   typedef struct packed {
      logic              capture;
      logic              sq_a;
      logic              sq_b;
      logic              sqrt_init;
      logic              sqrt_step;
      logic              mul;
      logic              num_load;
      logic              div_step;
      logic              div_rem;
      logic              acc_update;
      logic              cord_load;
      logic              cord_step;
      logic              cord_store;
      logic              mac_ang;
      logic              mac_lo;
      logic              mac_hi;
      logic              out_load;
      angle_type         angle;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } status_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:    v = 26'sd2949120;
         5'd1:    v = 26'sd1740967;
         5'd2:    v = 26'sd919879;
         5'd3:    v = 26'sd466945;
         5'd4:    v = 26'sd234379;
         5'd5:    v = 26'sd117304;
         5'd6:    v = 26'sd58666;
         5'd7:    v = 26'sd29335;
         5'd8:    v = 26'sd14668;
         5'd9:    v = 26'sd7334;
         5'd10:   v = 26'sd3667;
         5'd11:   v = 26'sd1833;
         5'd12:   v = 26'sd917;
         5'd13:   v = 26'sd458;
         5'd14:   v = 26'sd229;
         5'd15:   v = 26'sd115;
         5'd16:   v = 26'sd57;
         5'd17:   v = 26'sd29;
         5'd18:   v = 26'sd14;
         5'd19:   v = 26'sd7;
         5'd20:   v = 26'sd4;
         5'd21:   v = 26'sd2;
         5'd22:   v = 26'sd1;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/imu_tilt_complementary_filter.sv @@
`timescale 1ns / 1ps
// A request passes capture, two squares, the square root, the multiply, the rate division,
// yaw accumulation, three CORDIC passes, the blend and the output register.
// One request at a time: a new one is taken only when idle, after the radix-2048 rate divider,
// the serial square root and the single CORDIC shared by roll, pitch and yaw angle.
// Reset: synchronous; clears yaw accumulator, last timestamp, range, bias and valid flag.

module imu_tilt_complementary_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // temp_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw, accel_x_raw, accel_y_raw,
   // accel_z_raw, sample_time_us
   input  logic [itcf_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // temp_out, gyro_x_out, gyro_y_out, gyro_z_out, accel_x_out, accel_y_out,
   // accel_z_out, roll_angle, pitch_angle, yaw_angle
   output logic [itcf_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [16:0]                 csr_data
);
   import itcf_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = status.out_full;

   itcf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   itcf_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_data   (req_tdata),
      .rsp_data   (rsp_tdata),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule

@@ sv/itcf_ctrl.sv @@
`timescale 1ns / 1ps

module itcf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  itcf_pkg::status_type status,
   output itcf_pkg::cmd_type    cmd
);
   import itcf_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   angle_type        angle_ff, angle_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         angle_ff <= ANG_ROLL;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         angle_ff <= angle_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      angle_in   = angle_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.angle  = angle_ff;
      cmd.step   = cnt_ff[STEP_W-1:0];
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_SQ_A;
            end
         end
         S_SQ_A: begin
            cmd.sq_a = 1'b1;
            state_in = S_SQ_B;
         end
         S_SQ_B: begin
            cmd.sq_b = 1'b1;
            state_in = S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.sqrt_init = 1'b1;
            cnt_in        = '0;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_ITERS - 1)) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_NUM;
         end
         S_NUM: begin
            cmd.num_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = !cnt_ff[0];
            cmd.div_rem  = cnt_ff[0];
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_ITERS - 1)) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc_update = 1'b1;
            angle_in       = ANG_ROLL;
            state_in       = S_CORD_LOAD;
         end
         S_CORD_LOAD: begin
            cmd.cord_load = 1'b1;
            cnt_in        = '0;
            state_in      = S_CORD;
         end
         S_CORD: begin
            cmd.cord_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORD_ITERS - 1)) state_in = S_CORD_STORE;
         end
         S_CORD_STORE: begin
            cmd.cord_store = 1'b1;
            case (angle_ff)
               ANG_ROLL: begin
                  angle_in = ANG_PITCH;
                  state_in = S_CORD_LOAD;
               end
               ANG_PITCH: begin
                  angle_in = ANG_YAW;
                  state_in = S_CORD_LOAD;
               end
               default: state_in = S_MAC_ANG;
            endcase
         end
         S_MAC_ANG: begin
            cmd.mac_ang = 1'b1;
            state_in    = S_MAC_LO;
         end
         S_MAC_LO: begin
            cmd.mac_lo = 1'b1;
            state_in   = S_MAC_HI;
         end
         S_MAC_HI: begin
            cmd.mac_hi = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!status.out_full) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

@@ sv/itcf_dp.sv @@
`timescale 1ns / 1ps

module itcf_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  itcf_pkg::cmd_type            cmd,
   output itcf_pkg::status_type         status,
   input  logic [itcf_pkg::REQ_W-1:0]   req_data,
   output logic [itcf_pkg::RSP_W-1:0]   rsp_data,
   input  logic                         rsp_tready,
   input  logic                         csr_valid,
   input  logic [1:0]                   csr_index,
   input  logic [16:0]                  csr_data
);
   import itcf_pkg::*;

   localparam int F    = ACCUM_FRAC_BITS;
   localparam int SHL  = (F >= 16) ? F - 16 : 0;
   localparam int SHR  = (F < 16) ? 16 - F : 1;
   localparam int ASW  = ((QW > ACC_W) ? QW : ACC_W) + 2;
   localparam int YP_W = Y_W + RCP_W;
   localparam logic signed [ASW-1:0] ACC_HI = (ASW'(1) << (ACC_W - 1)) - ASW'(1);
   localparam logic signed [ASW-1:0] ACC_LO = -ACC_HI;

   logic [1:0]  range_ff;
   logic signed [15:0] bias_ff;
   logic [16:0] alpha_ff;

   logic [15:0] temp_ff, gx_ff, gy_ff, gz_ff;
   logic signed [15:0] ax_ff, ay_ff, az_ff;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic rneg_ff;
   logic [DT_W-1:0] dt_ff, dt_in;
   logic [63:0] last_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [31:0] sq_ff;
   logic [SQ_W-1:0] sn_ff, sres_ff, sbit_ff;
   logic [P_W-1:0] p_ff;
   logic [NUMP_W-1:0] num_ff;
   logic [REM_W-1:0] rem_ff;
   logic [Y_W-1:0] y_ff;
   logic [DIG_W-1:0] dig_ff;
   logic [QW-1:0] q_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [ZW-1:0] cz_ff;
   logic czero_ff;
   logic signed [ZW-1:0] roll_z_ff, pitch_z_ff, yaw_z_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [RSP_W-1:0] out_ff;
   logic out_full_ff;

   // capture-time arithmetic
   logic signed [16:0] gdiff;
   logic [16:0] gabs;
   logic [63:0] tdiff;
   logic signed [15:0] req_gz;
   logic [63:0] req_now;

   always_comb begin
      req_gz  = $signed(req_data[63:48]);
      req_now = req_data[175:112];
      gdiff   = 17'(req_gz) - 17'(bias_ff);
      gabs    = (gdiff < 0) ? 17'(-gdiff) : 17'(gdiff);
      mag_in  = MAG_W'(gabs) << range_ff;
      tdiff   = req_now - last_ff;
      if (last_ff == 64'd0) dt_in = '0;
      else if (tdiff[63:32] != 32'd0) dt_in = '1;
      else dt_in = tdiff[31:0];
   end

   // shared squaring multiplier
   logic signed [15:0] sq_op;
   logic signed [31:0] sq_prod;
   assign sq_op   = cmd.sq_a ? ay_ff : az_ff;
   assign sq_prod = sq_op * sq_op;

   // square root step
   logic [SQ_W-1:0] s_trial;
   assign s_trial = sres_ff + sbit_ff;

   // divider digit: reciprocal estimate, exact for a remainder below the divisor
   logic [Y_W-1:0]  y_in;
   logic [YP_W-1:0] y_prod;
   assign y_in   = {rem_ff, num_ff[NUMP_W-1 -: DIG_W]};
   assign y_prod = YP_W'(y_in) * YP_W'(DIV_RCP);

   // accumulator update
   logic signed [ASW-1:0] inc_e, acc_sum, acc_sat;
   always_comb begin
      inc_e   = $signed(ASW'(q_ff));
      acc_sum = ASW'(acc_ff) + (rneg_ff ? -inc_e : inc_e);
      if (acc_sum > ACC_HI) acc_sat = ACC_HI;
      else if (acc_sum < ACC_LO) acc_sat = ACC_LO;
      else acc_sat = acc_sum;
   end

   // cordic load and step
   logic signed [CW-1:0] xl, yl, xs, ys;
   logic signed [ZW-1:0] tab;
   always_comb begin
      case (cmd.angle)
         ANG_ROLL: begin
            yl = CW'(ay_ff) <<< 8;
            xl = CW'(az_ff) <<< 8;
         end
         ANG_PITCH: begin
            yl = -(CW'(ax_ff) <<< 8);
            xl = $signed(CW'(sres_ff[SQ_W/2-1:0]));
         end
         ANG_YAW: begin
            yl = CW'(ax_ff) <<< 8;
            xl = $signed(CW'(sres_ff[SQ_W/2-1:0]));
         end
         default: begin
            yl = '0;
            xl = '0;
         end
      endcase
      xs  = cx_ff >>> cmd.step;
      ys  = cy_ff >>> cmd.step;
      tab = atan_entry(cmd.step);
   end

   // blend
   logic [16:0] alpha_c, wgt;
   logic signed [ZW-1:0] ang_rnd, ang_p;
   logic signed [43:0] p_ang;
   logic [40:0] p_lo;
   logic signed [41:0] p_hi;
   always_comb begin
      alpha_c = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
      wgt     = ALPHA_ONE - alpha_c;
      ang_rnd = ((yaw_z_ff >>> (SHR - 1)) + ZW'(1)) >>> 1;
      ang_p   = (F >= 16) ? yaw_z_ff : ang_rnd;
      p_ang   = $signed({1'b0, wgt}) * ang_p;
      p_lo    = 41'(alpha_c) * 41'(acc_ff[23:0]);
      p_hi    = $signed({1'b0, alpha_c}) * $signed(acc_ff[47:24]);
   end

   // output rounding
   function automatic logic [15:0] out_angle(input logic signed [ZW-1:0] z);
      logic signed [ZW-1:0] r;
      r = ((z >>> 8) + ZW'(1)) >>> 1;
      if (r > 26'sd23040) r = 26'sd23040;
      else if (r < -26'sd23040) r = -26'sd23040;
      return r[15:0];
   endfunction

   logic signed [SUM_W-1:0] yaw_r;
   logic [23:0] yaw_o;
   always_comb begin
      yaw_r = ((sum_ff >>> (F + 8)) + SUM_W'(1)) >>> 1;
      if (yaw_r > 66'sd8388607) yaw_o = 24'h7FFFFF;
      else if (yaw_r < -66'sd8388608) yaw_o = 24'h800000;
      else yaw_o = yaw_r[23:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff    <= '0;
         bias_ff     <= '0;
         alpha_ff    <= ALPHA_RESET;
         last_ff     <= '0;
         acc_ff      <= '0;
         out_full_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_GYRO_RANGE:   range_ff <= csr_data[1:0];
               CSR_GYRO_BIAS:    bias_ff  <= $signed(csr_data[15:0]);
               CSR_FILTER_ALPHA: alpha_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.capture) last_ff <= req_now;
         if (cmd.acc_update) acc_ff <= acc_sat[ACC_W-1:0];
         if (cmd.out_load) out_full_ff <= 1'b1;
         else if (rsp_tready) out_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         temp_ff <= req_data[15:0];
         gx_ff   <= req_data[31:16];
         gy_ff   <= req_data[47:32];
         gz_ff   <= req_data[63:48];
         ax_ff   <= $signed(req_data[79:64]);
         ay_ff   <= $signed(req_data[95:80]);
         az_ff   <= $signed(req_data[111:96]);
         mag_ff  <= mag_in;
         rneg_ff <= gdiff < 0;
         dt_ff   <= dt_in;
      end
      if (cmd.sq_a) sq_ff <= unsigned'(sq_prod);
      if (cmd.sq_b) sq_ff <= sq_ff + unsigned'(sq_prod);
      if (cmd.sqrt_init) begin
         sn_ff   <= {sq_ff, 16'd0};
         sres_ff <= '0;
         sbit_ff <= SQ_W'(1) << (SQ_W - 2);
      end
      if (cmd.sqrt_step) begin
         if (sn_ff >= s_trial) begin
            sn_ff   <= sn_ff - s_trial;
            sres_ff <= (sres_ff >> 1) + sbit_ff;
         end else begin
            sres_ff <= sres_ff >> 1;
         end
         sbit_ff <= sbit_ff >> 2;
      end
      if (cmd.mul) p_ff <= P_W'(mag_ff) * P_W'(dt_ff);
      if (cmd.num_load) begin
         num_ff <= (NUMP_W'(p_ff) << (F - CUT_SH)) + NUMP_W'(DIV_HALF);
         rem_ff <= '0;
         q_ff   <= '0;
      end
      if (cmd.div_step) begin
         y_ff   <= y_in;
         dig_ff <= y_prod[RCP_SH +: DIG_W];
         num_ff <= num_ff << DIG_W;
      end
      if (cmd.div_rem) begin
         rem_ff <= REM_W'(y_ff - Y_W'(dig_ff) * Y_W'(DIV_B));
         q_ff   <= {q_ff[QW-DIG_W-1:0], dig_ff};
      end
      if (cmd.cord_load) begin
         czero_ff <= (xl == 0) && (yl == 0);
         if (xl < 0) begin
            cz_ff <= (yl >= 0) ? DEG180 : -DEG180;
            cx_ff <= -xl;
            cy_ff <= -yl;
         end else begin
            cz_ff <= '0;
            cx_ff <= xl;
            cy_ff <= yl;
         end
      end
      if (cmd.cord_step) begin
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + tab;
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - tab;
         end
      end
      if (cmd.cord_store) begin
         case (cmd.angle)
            ANG_ROLL:  roll_z_ff  <= czero_ff ? '0 : cz_ff;
            ANG_PITCH: pitch_z_ff <= czero_ff ? '0 : cz_ff;
            default:   yaw_z_ff   <= czero_ff ? '0 : cz_ff;
         endcase
      end
      if (cmd.mac_ang) sum_ff <= SUM_W'(p_ang) <<< SHL;
      if (cmd.mac_lo) sum_ff <= sum_ff + $signed(SUM_W'(p_lo));
      if (cmd.mac_hi) sum_ff <= sum_ff + (SUM_W'(p_hi) <<< 24);
      if (cmd.out_load) begin
         out_ff <= {yaw_o, out_angle(pitch_z_ff), out_angle(roll_z_ff),
                    az_ff, ay_ff, ax_ff, gz_ff, gy_ff, gx_ff, temp_ff};
      end
   end

   assign status.out_full = out_full_ff;
   assign rsp_data        = out_ff;

endmodule

@@ sv/itcf_checker.sv @@
`timescale 1ns / 1ps

module itcf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [itcf_pkg::RSP_W-1:0]  rsp_tdata
);
   import itcf_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response too early");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[127:112]) >= -16'sd23040) &&
                     ($signed(rsp_tdata[127:112]) <= 16'sd23040))
      else $error("roll out of range");

endmodule

bind imu_tilt_complementary_filter itcf_checker u_chk (.*);
